// ===== design/wnrp_pkg.sv =====
// Package for the window nearest-rank percentile block.
// Holds the field widths, the default window capacity and the result struct.
// No dependencies.
package wnrp_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W = 18;
    localparam int FRAC_CLAMP_W = 17;
    localparam int COUNT_OUT_W = 8;
    localparam int Q16_SHIFT = 16;
    localparam int CAPACITY_DEFAULT = 128;

    localparam logic [FRAC_CLAMP_W-1:0] ONE_Q16 = FRAC_CLAMP_W'(65536);
    localparam logic [Q16_SHIFT-1:0] ROUND_UP_Q16 = Q16_SHIFT'(65535);

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] value;
    } sel_result_t;

endpackage

// ===== design/wnrp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameters set word width and depth. No dependencies.
module wnrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/wnrp_select.sv =====
// Rank selection engine for the window nearest-rank percentile block.
// Scans the sample RAM through its read port, one candidate at a time.
// Depends on wnrp_pkg.
module wnrp_select #(
    parameter int CAPACITY = wnrp_pkg::CAPACITY_DEFAULT,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic [CNT_W-1:0]                    n,
    input  logic [CNT_W-1:0]                    rank,
    output logic                                rd_en,
    output logic [ADDR_W-1:0]                   rd_addr,
    input  logic [wnrp_pkg::SAMPLE_W-1:0]       rd_data,
    output wnrp_pkg::sel_result_t               res
);

    import wnrp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CREAD = 3'd1;
    localparam logic [2:0] S_CWAIT = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cand_idx_reg, cand_idx_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]    lt_reg, lt_next;
    logic [CNT_W-1:0]    le_reg, le_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [SAMPLE_W-1:0] cand_reg, cand_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W-1:0] value_reg, value_next;
    logic                issue;
    logic                hit;

    assign issue = (scan_idx_reg < n);
    assign hit = (lt_reg < rank) && (rank <= le_reg);

    assign rd_en = (state_reg == S_CREAD) || ((state_reg == S_SCAN) && issue);
    assign rd_addr = (state_reg == S_CREAD) ? cand_idx_reg[ADDR_W-1:0]
                                            : scan_idx_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cand_idx_next = cand_idx_reg;
        scan_idx_next = scan_idx_reg;
        lt_next = lt_reg;
        le_next = le_reg;
        cmp_vld_next = cmp_vld_reg;
        cand_next = cand_reg;
        done_next = 1'b0;
        value_next = value_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    cand_idx_next = '0;
                    state_next = S_CREAD;
                end
            end
            S_CREAD:
            begin
                cmp_vld_next = 1'b0;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                cand_next = rd_data;
                scan_idx_next = '0;
                lt_next = '0;
                le_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cmp_vld_reg)
                begin
                    if (rd_data < cand_reg)
                    begin
                        lt_next = lt_reg + 1'b1;
                    end
                    if (rd_data <= cand_reg)
                    begin
                        le_next = le_reg + 1'b1;
                    end
                end
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    done_next = 1'b1;
                    value_next = cand_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                    state_next = S_CREAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_idx_reg <= cand_idx_next;
        scan_idx_reg <= scan_idx_next;
        lt_reg <= lt_next;
        le_reg <= le_next;
        cand_reg <= cand_next;
        value_reg <= value_next;
    end

    assign res.done = done_reg;
    assign res.value = value_reg;

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= n))
        else $error("scan index ran past the window");

    a_cand_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CREAD) |-> (cand_idx_reg < n))
        else $error("candidate index left the window without a hit");

    a_le_covers_lt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (lt_reg <= le_reg))
        else $error("less-than count exceeds less-or-equal count");

endmodule

// ===== design/window_nearest_rank_percentile_top.sv =====
// Top level of the window nearest-rank percentile block.
// Instantiates wnrp_ram and wnrp_select; depends on wnrp_pkg.
//
// Usage: a request is accepted at a rising edge where start is high and busy
// is low. Each request carries one sample; the request with is_last high also
// carries fraction_q16 and closes the window. Samples are written into the
// sample RAM as they arrive, one request per cycle, so busy stays low while a
// window fills. Samples beyond CAPACITY are dropped and flagged.
// After the last request busy rises while the nearest-rank sample is found:
// the rank is computed first, then each candidate sample is read and
// compared against all n held samples through the single RAM read port.
// Candidates are tried in order of position, and the result is the first
// held sample whose value lies at the target rank.
// The result shows on percentile_value, window_count and overflowed for one
// cycle, marked by done; the receiver cannot stall and busy falls at the edge
// that ends that cycle. The window is then empty and the next request may
// start a new one.
// Reset clears the sample count, the drop flag and all control state; the RAM
// contents are not cleared, since only written entries are ever read.
module window_nearest_rank_percentile_top #(
    parameter int CAPACITY = wnrp_pkg::CAPACITY_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [wnrp_pkg::SAMPLE_W-1:0]        sample,
    input  logic                                 is_last,
    input  logic signed [wnrp_pkg::FRAC_W-1:0]   fraction_q16,
    output logic                                 done,
    output logic [wnrp_pkg::SAMPLE_W-1:0]        percentile_value,
    output logic [wnrp_pkg::COUNT_OUT_W-1:0]     window_count,
    output logic                                 overflowed
);

    import wnrp_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PROD_W = FRAC_CLAMP_W + CNT_W;
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RANK   = 2'd1;
    localparam logic [1:0] ST_LAUNCH = 2'd2;
    localparam logic [1:0] ST_WAIT   = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic                    drop_reg, drop_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic                    drop_out_reg, drop_out_next;
    logic [FRAC_CLAMP_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]        rank_reg, rank_next;

    logic                    accept;
    logic                    room;
    logic [CNT_W-1:0]        held_inc;
    logic [FRAC_CLAMP_W-1:0] frac_clamped;
    logic [PROD_W-1:0]       product;
    logic [PROD_W-1:0]       rounded;
    logic [CNT_W:0]          rank_raw;
    logic [CNT_W+COUNT_OUT_W-1:0] n_wide;

    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SAMPLE_W-1:0]     rd_data;
    sel_result_t             sel_res;

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign room = (held_reg < CAP_COUNT);
    assign held_inc = held_reg + 1'b1;

    always_comb
    begin
        if (fraction_q16[FRAC_W-1])
        begin
            frac_clamped = '0;
        end
        else if (fraction_q16[FRAC_CLAMP_W-1:0] > ONE_Q16)
        begin
            frac_clamped = ONE_Q16;
        end
        else
        begin
            frac_clamped = fraction_q16[FRAC_CLAMP_W-1:0];
        end
    end

    assign product = PROD_W'(frac_reg) * PROD_W'(n_reg);
    assign rounded = product + PROD_W'(ROUND_UP_Q16);
    assign rank_raw = (CNT_W + 1)'(rounded >> Q16_SHIFT);

    always_comb
    begin
        state_next = state_reg;
        held_next = held_reg;
        drop_next = drop_reg;
        n_next = n_reg;
        drop_out_next = drop_out_reg;
        frac_next = frac_reg;
        rank_next = rank_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_last)
                    begin
                        n_next = room ? held_inc : held_reg;
                        drop_out_next = drop_reg || !room;
                        frac_next = frac_clamped;
                        held_next = '0;
                        drop_next = 1'b0;
                        state_next = ST_RANK;
                    end
                    else if (room)
                    begin
                        held_next = held_inc;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            ST_RANK:
            begin
                if (rank_raw == '0)
                begin
                    rank_next = CNT_W'(1);
                end
                else if (rank_raw > {1'b0, n_reg})
                begin
                    rank_next = n_reg;
                end
                else
                begin
                    rank_next = rank_raw[CNT_W-1:0];
                end
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sel_res.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg <= held_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        drop_out_reg <= drop_out_next;
        frac_reg <= frac_next;
        rank_reg <= rank_next;
    end

    wnrp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && room),
        .wr_addr (held_reg[ADDR_W-1:0]),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wnrp_select #(
        .CAPACITY (CAPACITY)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (state_reg == ST_LAUNCH),
        .n       (n_reg),
        .rank    (rank_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (sel_res)
    );

    assign n_wide = {{COUNT_OUT_W{1'b0}}, n_reg};

    assign done = sel_res.done;
    assign percentile_value = sel_res.value;
    assign window_count = n_wide[COUNT_OUT_W-1:0];
    assign overflowed = drop_out_reg;

    a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sel_res.done |-> (state_reg == ST_WAIT))
        else $error("result strobe outside of a pending selection");

    a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAUNCH) |-> ((rank_reg != '0) && (rank_reg <= n_reg)))
        else $error("rank outside 1..count at launch");

    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CAP_COUNT)
        else $error("held count exceeds capacity");

    a_window_emptied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RANK) |-> ((held_reg == '0) && !drop_reg && (n_reg != '0)))
        else $error("window not emptied after the last request");

endmodule
